### rtl/b2fc_pkg.sv
// Shared types and constants for the block-to-floppy-command converter.
// Used by every module under rtl; depends on nothing.
package b2fc_pkg;

    localparam int START_W    = 16;
    localparam int COUNT_W    = 25;
    localparam int DRIVE_W    = 2;
    localparam int BYTE_W     = 8;
    localparam int MEDIUM_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_BLOCK_SHIFT = 9;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Four quotient bits are resolved per divider cycle.
    localparam int DIV_BITS  = 4;
    localparam int CYL_STEPS = START_W / DIV_BITS;
    localparam int HEAD_STEPS = BYTE_W / DIV_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_SPC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP = 2'd3;

    localparam logic [BYTE_W-1:0]   RST_SPC = 8'd36;
    localparam logic [BYTE_W-1:0]   RST_SPT = 8'd18;
    localparam logic [MEDIUM_W-1:0] RST_SPM = 16'd2880;
    localparam logic [BYTE_W-1:0]   RST_GAP = 8'd27;

    localparam logic [BYTE_W-1:0] OPCODE_READ  = 8'hC6;
    localparam logic [BYTE_W-1:0] OPCODE_WRITE = 8'hC5;
    localparam logic [BYTE_W-1:0] SIZE_CODE    = 8'h02;
    localparam logic [BYTE_W-1:0] DATA_LENGTH  = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0]   spc;
        logic [BYTE_W-1:0]   spt;
        logic [MEDIUM_W-1:0] spm;
        logic [BYTE_W-1:0]   gap;
    } t_cfg;

    typedef struct packed {
        logic               err;
        logic               rd;
        logic [DRIVE_W-1:0] drv;
        logic [BYTE_W-1:0]  cyl;
        logic [BYTE_W-1:0]  head;
        logic [BYTE_W-1:0]  sec1;
    } t_cmd;

    typedef enum logic [1:0] {
        E_IDLE,
        E_CYL,
        E_HEAD,
        E_PUSH
    } t_eng_state;

    typedef enum logic [3:0] {
        SEL_OPCODE,
        SEL_HEAD_DRV,
        SEL_CYL,
        SEL_HEAD,
        SEL_SECTOR,
        SEL_SIZE,
        SEL_EOT,
        SEL_GAP,
        SEL_DTL
    } t_byte_sel;

endpackage

### rtl/b2fc_front.sv
// Front end: input holding register, medium bound check and the iterative
// cylinder/head/sector divider. Depends on b2fc_pkg.
module b2fc_front #(
    parameter int BLOCK_SHIFT = b2fc_pkg::DEF_BLOCK_SHIFT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  b2fc_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [b2fc_pkg::START_W-1:0]   i_start_block,
    input  logic [b2fc_pkg::COUNT_W-1:0]   i_byte_count,
    input  logic                           i_is_read,
    input  logic [b2fc_pkg::DRIVE_W-1:0]   i_drive,
    output logic                           o_push,
    output b2fc_pkg::t_cmd                 o_entry,
    input  logic                           i_full
);
    import b2fc_pkg::*;

    localparam int BLK_W  = COUNT_W + 1 - BLOCK_SHIFT;
    localparam int SUM_W  = ((BLK_W > START_W) ? BLK_W : START_W) + 1;
    localparam int STEP_W = $clog2(CYL_STEPS);
    localparam logic [COUNT_W:0] ROUND = (COUNT_W + 1)'((1 << BLOCK_SHIFT) - 1);

    logic                r_hold_vld;
    logic [START_W-1:0]  r_hold_start;
    logic [COUNT_W-1:0]  r_hold_count;
    logic                r_hold_rd;
    logic [DRIVE_W-1:0]  r_hold_drv;

    t_eng_state          r_state, n_state;
    logic [BYTE_W-1:0]   r_rem, n_rem;
    logic [START_W-1:0]  r_quo, n_quo;
    logic [BYTE_W-1:0]   r_div, n_div;
    logic [STEP_W-1:0]   r_step, n_step;
    t_cmd                r_entry, n_entry;

    logic                take;
    logic [COUNT_W:0]    round_sum;
    logic [BLK_W-1:0]    blocks;
    logic [SUM_W-1:0]    end_block;
    logic                over;
    logic [BYTE_W-1:0]   spc_eff, spt_eff;
    logic [BYTE_W-1:0]   step_rem;
    logic [START_W-1:0]  step_quo;

    assign o_ready = !r_hold_vld || take;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_hold_vld <= 1'b1;
        end else if (take) begin
            r_hold_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_hold_start <= i_start_block;
            r_hold_count <= i_byte_count;
            r_hold_rd    <= i_is_read;
            r_hold_drv   <= i_drive;
        end
    end

    assign round_sum = {1'b0, r_hold_count} + ROUND;
    assign blocks    = round_sum[COUNT_W:BLOCK_SHIFT];
    assign end_block = SUM_W'(r_hold_start) + SUM_W'(blocks);
    assign over      = end_block > SUM_W'(i_cfg.spm);
    assign spc_eff   = (i_cfg.spc == '0) ? BYTE_W'(1) : i_cfg.spc;
    assign spt_eff   = (i_cfg.spt == '0) ? BYTE_W'(1) : i_cfg.spt;

    // Restoring division, several quotient bits per cycle.
    always_comb begin
        logic [BYTE_W:0] trial;
        step_rem = r_rem;
        step_quo = r_quo;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial    = {step_rem, step_quo[START_W-1]};
            step_quo = {step_quo[START_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                step_rem    = BYTE_W'(trial - {1'b0, r_div});
                step_quo[0] = 1'b1;
            end else begin
                step_rem = trial[BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_step  <= n_step;
        r_entry <= n_entry;
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_step  = r_step;
        n_entry = r_entry;
        take    = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (r_hold_vld) begin
                    take         = 1'b1;
                    n_entry.err  = over;
                    n_entry.rd   = r_hold_rd;
                    n_entry.drv  = r_hold_drv;
                    n_rem        = '0;
                    n_quo        = r_hold_start;
                    n_div        = spc_eff;
                    n_step       = '0;
                    n_state      = over ? E_PUSH : E_CYL;
                end
            end
            E_CYL: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CYL_STEPS - 1)) begin
                    n_entry.cyl = step_quo[BYTE_W-1:0];
                    n_rem       = '0;
                    n_quo       = {step_rem, {(START_W - BYTE_W){1'b0}}};
                    n_div       = spt_eff;
                    n_step      = '0;
                    n_state     = E_HEAD;
                end
            end
            E_HEAD: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(HEAD_STEPS - 1)) begin
                    n_entry.head = step_quo[BYTE_W-1:0];
                    n_entry.sec1 = step_rem + 1'b1;
                    n_state      = E_PUSH;
                end
            end
            E_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = E_IDLE;
                end
            end
        endcase
    end

endmodule

### rtl/b2fc_queue.sv
// Short command queue between the front end and the byte sequencer.
// Depends on b2fc_pkg.
module b2fc_queue #(
    parameter int DEPTH = b2fc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b2fc_pkg::t_cmd  i_entry,
    output logic            o_full,
    output logic            o_nonempty,
    input  logic            i_pop,
    output b2fc_pkg::t_cmd  o_entry
);
    import b2fc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_entry    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/b2fc_back.sv
// Back end: steps through the nine command bytes of each queued entry, or
// gives the single error beat. Depends on b2fc_pkg.
module b2fc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b2fc_pkg::t_cfg               i_cfg,
    input  logic                         i_q_nonempty,
    output logic                         o_pop,
    input  b2fc_pkg::t_cmd               i_entry,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b2fc_pkg::BYTE_W-1:0]  o_command_byte,
    output logic                         o_error,
    output logic                         o_last
);
    import b2fc_pkg::*;

    logic      r_cur_vld;
    t_cmd      r_cur;
    t_byte_sel r_sel;
    logic      beat, done;

    assign o_valid = r_cur_vld;
    assign o_error = r_cur.err;
    assign o_last  = r_cur.err || (r_sel == SEL_DTL);
    assign beat    = r_cur_vld && i_ready;
    assign done    = beat && o_last;
    assign o_pop   = (!r_cur_vld || done) && i_q_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_sel     <= SEL_OPCODE;
        end else if (o_pop) begin
            r_cur_vld <= 1'b1;
            r_sel     <= SEL_OPCODE;
        end else if (done) begin
            r_cur_vld <= 1'b0;
        end else if (beat) begin
            r_sel <= t_byte_sel'(r_sel + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

    always_comb begin
        o_command_byte = '0;
        if (!r_cur.err) begin
            unique case (r_sel)
                SEL_OPCODE:   o_command_byte = r_cur.rd ? OPCODE_READ : OPCODE_WRITE;
                SEL_HEAD_DRV: o_command_byte = {r_cur.head[BYTE_W-DRIVE_W-1:0], r_cur.drv};
                SEL_CYL:      o_command_byte = r_cur.cyl;
                SEL_HEAD:     o_command_byte = r_cur.head;
                SEL_SECTOR:   o_command_byte = r_cur.sec1;
                SEL_SIZE:     o_command_byte = SIZE_CODE;
                SEL_EOT:      o_command_byte = i_cfg.spt;
                SEL_GAP:      o_command_byte = i_cfg.gap;
                SEL_DTL:      o_command_byte = DATA_LENGTH;
                default:      o_command_byte = '0;
            endcase
        end
    end

endmodule

### rtl/block_to_floppy_command.sv
// Block request to floppy read/write command converter, top level.
// An accepted request waits in the front end's holding register, which takes the next request
// while the divider (four quotient bits a cycle) works; results pass the command queue to the
// byte sequencer, which offers the command bytes and sets the throughput. An out-of-range
// request skips the divider and gives a single error beat. Synchronous active-low reset
// restores the geometry registers and empties every stage.
module block_to_floppy_command #(
    parameter int BLOCK_SHIFT = b2fc_pkg::DEF_BLOCK_SHIFT,
    parameter int QUEUE_DEPTH = b2fc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [b2fc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [b2fc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [b2fc_pkg::START_W-1:0]      i_start_block,
    input  logic [b2fc_pkg::COUNT_W-1:0]      i_byte_count,
    input  logic                              i_is_read,
    input  logic [b2fc_pkg::DRIVE_W-1:0]      i_drive,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [b2fc_pkg::BYTE_W-1:0]       o_command_byte,
    output logic                              o_error,
    output logic                              o_last
);
    import b2fc_pkg::*;

    t_cfg r_cfg;
    logic push, full, q_nonempty, pop;
    t_cmd front_entry, queue_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spc <= RST_SPC;
            r_cfg.spt <= RST_SPT;
            r_cfg.spm <= RST_SPM;
            r_cfg.gap <= RST_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPC: r_cfg.spc <= i_cfg_data[BYTE_W-1:0];
                CFG_SPT: r_cfg.spt <= i_cfg_data[BYTE_W-1:0];
                CFG_SPM: r_cfg.spm <= i_cfg_data[MEDIUM_W-1:0];
                CFG_GAP: r_cfg.gap <= i_cfg_data[BYTE_W-1:0];
            endcase
        end
    end

    b2fc_front #(
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_block (i_start_block),
        .i_byte_count  (i_byte_count),
        .i_is_read     (i_is_read),
        .i_drive       (i_drive),
        .o_push        (push),
        .o_entry       (front_entry),
        .i_full        (full)
    );

    b2fc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (front_entry),
        .o_full     (full),
        .o_nonempty (q_nonempty),
        .i_pop      (pop),
        .o_entry    (queue_entry)
    );

    b2fc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_nonempty   (q_nonempty),
        .o_pop          (pop),
        .i_entry        (queue_entry),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command_byte (o_command_byte),
        .o_error        (o_error),
        .o_last         (o_last)
    );

endmodule

### rtl/b2fc_checker.sv
// Port-level checks for block_to_floppy_command, with the bind that attaches
// them. Depends on b2fc_pkg.
module b2fc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [b2fc_pkg::BYTE_W-1:0] o_command_byte,
    input logic                        o_error,
    input logic                        o_last
);
    import b2fc_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_command_byte)
            && $stable(o_error) && $stable(o_last))
        else $error("result beat changed while stalled");

    // An error is a single, final beat carrying a zero byte.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && (o_command_byte == '0))
        else $error("error beat is not a lone zero beat");

    // Command bytes of one request follow without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && !o_error)
        else $error("gap or error inside a command");

    // The final byte of a command is the data length byte.
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_error |-> o_command_byte == DATA_LENGTH)
        else $error("command does not end with the data length byte");

    // A command offered right after the last beat of the previous one opens with a read or write opcode.
    a_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> !o_valid || o_error
            || (o_command_byte == OPCODE_READ) || (o_command_byte == OPCODE_WRITE))
        else $error("command does not open with an opcode");

endmodule

bind block_to_floppy_command b2fc_checker u_b2fc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_command_byte (o_command_byte),
    .o_error        (o_error),
    .o_last         (o_last)
);

### tb/block_to_floppy_command_test.sv
// Self-checking testbench for block_to_floppy_command: transfer requests go in,
// floppy command beats come out and are compared with a built-in predictor.
// Depends on b2fc_pkg and the block_to_floppy_command RTL only.
module block_to_floppy_command_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b2fc_pkg::*;

    localparam int BLOCK_SHIFT = DEF_BLOCK_SHIFT;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [START_W-1:0] start_block;
        logic [COUNT_W-1:0] byte_count;
        logic               is_read;
        logic [DRIVE_W-1:0] drive;
    } t_transfer_request;

    typedef struct {
        logic [BYTE_W-1:0] command_byte;
        logic              error;
        logic              last;
    } t_command_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [START_W-1:0]    i_start_block = '0;
    logic [COUNT_W-1:0]    i_byte_count = '0;
    logic                  i_is_read = 1'b0;
    logic [DRIVE_W-1:0]    i_drive = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [BYTE_W-1:0]     o_command_byte;
    logic                  o_error;
    logic                  o_last;

    t_transfer_request pending_requests[$];
    t_command_beat     expected_beats[$];
    t_cfg              disk_geom;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;

    block_to_floppy_command DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_block  (i_start_block),
        .i_byte_count   (i_byte_count),
        .i_is_read      (i_is_read),
        .i_drive        (i_drive),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command_byte (o_command_byte),
        .o_error        (o_error),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_command(logic [START_W-1:0] start, logic [COUNT_W-1:0] count,
                                            logic rd, logic [DRIVE_W-1:0] drv);
        int unsigned       blocks;
        int unsigned       spc;
        int unsigned       spt;
        int unsigned       cyl;
        int unsigned       in_cyl;
        int unsigned       head;
        int unsigned       sec;
        logic [BYTE_W-1:0] cmd [9];
        blocks = (32'(count) + (32'd1 << BLOCK_SHIFT) - 32'd1) >> BLOCK_SHIFT;
        if (32'(start) + blocks > 32'(disk_geom.spm)) begin
            expected_beats.push_back(t_command_beat'{8'h00, 1'b1, 1'b1});
        end else begin
            spc = (disk_geom.spc == 0) ? 1 : 32'(disk_geom.spc);
            spt = (disk_geom.spt == 0) ? 1 : 32'(disk_geom.spt);
            cyl = 32'(start) / spc;
            in_cyl = 32'(start) % spc;
            head = in_cyl / spt;
            sec = in_cyl % spt;
            cmd = '{rd ? OPCODE_READ : OPCODE_WRITE, BYTE_W'((head << 2) | 32'(drv)),
                    BYTE_W'(cyl), BYTE_W'(head), BYTE_W'(sec + 1), SIZE_CODE,
                    disk_geom.spt, disk_geom.gap, DATA_LENGTH};
            for (int i = 0; i < 9; i++) begin
                expected_beats.push_back(t_command_beat'{cmd[i], 1'b0, i == 8});
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_transfer_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_command(i_start_block, i_byte_count, i_is_read, i_drive);
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_start_block <= req.start_block;
                    i_byte_count  <= req.byte_count;
                    i_is_read     <= req.is_read;
                    i_drive       <= req.drive;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_command_beat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("Unexpected beat: command_byte %0h error %0b last %0b",
                           o_command_byte, o_error, o_last);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_command_byte !== want.command_byte) begin
                        $error("command_byte: expected %0h, actual %0h",
                               want.command_byte, o_command_byte);
                        mismatches++;
                    end
                    if (o_error !== want.error) begin
                        $error("error: expected %0b, actual %0b", want.error, o_error);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, o_last);
                        mismatches++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_valid || expected_beats.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [BYTE_W-1:0] spc, logic [BYTE_W-1:0] spt,
                                logic [MEDIUM_W-1:0] spm, logic [BYTE_W-1:0] gap);
        wait_drained();
        write_reg(CFG_SPC, CFG_DATA_W'(spc));
        write_reg(CFG_SPT, CFG_DATA_W'(spt));
        write_reg(CFG_SPM, CFG_DATA_W'(spm));
        write_reg(CFG_GAP, CFG_DATA_W'(gap));
        disk_geom.spc = spc;
        disk_geom.spt = spt;
        disk_geom.spm = spm;
        disk_geom.gap = gap;
        @(posedge i_clk);
    endtask

    task automatic queue_request(int unsigned start, int unsigned count, bit rd, int unsigned drv);
        pending_requests.push_back(t_transfer_request'{START_W'(start), COUNT_W'(count), rd,
                                                       DRIVE_W'(drv)});
    endtask

    task automatic queue_random(int n);
        int unsigned pick;
        int unsigned start;
        int unsigned room;
        int unsigned count;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 15 || disk_geom.spm == 0) begin
                start = $urandom;
                count = $urandom;
            end else begin
                start = $urandom_range(32'(disk_geom.spm) - 1);
                room = 32'(disk_geom.spm) - start;
                if (pick < 35) begin
                    count = (room << BLOCK_SHIFT) + $urandom_range(1);
                end else begin
                    count = $urandom_range(((room < 64) ? room : 64) << BLOCK_SHIFT);
                end
            end
            queue_request(start, count, $urandom_range(1), $urandom_range(3));
        end
    endtask

    initial begin
        disk_geom = '{spc: RST_SPC, spt: RST_SPT, spm: RST_SPM, gap: RST_GAP};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 76;
        queue_request(0, 0, 1, 0);
        queue_request(2879, 512, 0, 3);
        queue_request(2879, 513, 1, 1);
        queue_request(2880, 0, 0, 2);
        queue_request(35, 1, 1, 1);
        queue_request(18, 1024, 0, 2);
        queue_request(0, 1474560, 1, 0);
        queue_request(65535, 33554431, 0, 3);
        queue_random(35);

        set_geometry(8'd255, 8'd255, 16'd65535, 8'd255);
        queue_request(65535, 0, 1, 3);
        queue_request(254, 0, 0, 1);
        queue_request(0, 33554431, 1, 2);
        queue_request(0, 33553920, 0, 0);
        queue_random(35);

        set_geometry(8'd1, 8'd1, 16'd0, 8'd0);
        send_idle_pct = 76;
        recv_idle_pct = 15;
        queue_request(0, 0, 1, 3);
        queue_request(0, 1, 0, 0);
        queue_request(1, 0, 1, 1);
        queue_random(20);

        set_geometry(8'd0, 8'd0, 16'd1000, 8'd42);
        queue_request(999, 1, 0, 2);
        queue_request(0, 0, 1, 1);
        queue_request(500, 0, 1, 3);
        queue_random(35);

        set_geometry(8'd255, 8'd1, 16'd65535, 8'h80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_request(254, 0, 1, 3);
        queue_request(510, 0, 0, 2);
        queue_random(35);

        set_geometry(8'd160, 8'd80, 16'd5760, 8'h1B);
        queue_request(5759, 512, 1, 0);
        queue_random(35);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
